// ===== rtl/grwc_pkg.sv =====
// Shared constants and the tangent table for the grid ray wall caster.
// No dependencies; the interfaces, the top level and the checker import it.
package grwc_pkg;

  localparam int MAP_SIZE      = 8;
  localparam int CELL_SIZE     = 64;
  localparam int MAX_STEPS     = 8;
  localparam int SCREEN_HEIGHT = 320;

  // field widths
  localparam int POS_W    = 17;
  localparam int ANG_W    = 16;
  localparam int DIST_W   = 18;
  localparam int HEIGHT_W = 9;
  localparam int OFFSET_W = 8;
  localparam int MAP_BITS = MAP_SIZE * MAP_SIZE;

  // grid geometry in Q8 pixels
  localparam int CELL_Q     = CELL_SIZE * 256;
  localparam int CELL_SHIFT = $clog2(CELL_Q);

  localparam int DIST_SAT   = 2**DIST_W - 1;
  localparam int HEIGHT_NUM = CELL_SIZE * SCREEN_HEIGHT * 256;
  // below this distance the column height clamps to the screen
  localparam int NEAR_DIST  = HEIGHT_NUM / SCREEN_HEIGHT;

  // tangent table, Q16, 33 entries over one octant
  localparam int TAN_W  = 17;
  localparam int TIDX_W = 6;

  function automatic logic [TAN_W-1:0] tan_tab(input logic [TIDX_W-1:0] k);
    logic [TAN_W-1:0] v;
    case (k)
      6'd0:  v = 17'd0;
      6'd1:  v = 17'd1609;
      6'd2:  v = 17'd3220;
      6'd3:  v = 17'd4834;
      6'd4:  v = 17'd6455;
      6'd5:  v = 17'd8083;
      6'd6:  v = 17'd9721;
      6'd7:  v = 17'd11372;
      6'd8:  v = 17'd13036;
      6'd9:  v = 17'd14717;
      6'd10: v = 17'd16416;
      6'd11: v = 17'd18136;
      6'd12: v = 17'd19880;
      6'd13: v = 17'd21650;
      6'd14: v = 17'd23449;
      6'd15: v = 17'd25280;
      6'd16: v = 17'd27146;
      6'd17: v = 17'd29050;
      6'd18: v = 17'd30996;
      6'd19: v = 17'd32988;
      6'd20: v = 17'd35030;
      6'd21: v = 17'd37126;
      6'd22: v = 17'd39281;
      6'd23: v = 17'd41500;
      6'd24: v = 17'd43790;
      6'd25: v = 17'd46156;
      6'd26: v = 17'd48605;
      6'd27: v = 17'd51145;
      6'd28: v = 17'd53784;
      6'd29: v = 17'd56532;
      6'd30: v = 17'd59398;
      6'd31: v = 17'd62395;
      default: v = 17'd65536;  // 45 degrees and beyond
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/grwc_ray_if.sv =====
// Ray word channel: player position and ray angle, valid/ready handshake.
// Depends on grwc_pkg.
interface grwc_ray_if;
  import grwc_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] player_x;
  logic [POS_W-1:0] player_y;
  logic [ANG_W-1:0] ray_angle;

  modport source (output valid, player_x, player_y, ray_angle, input ready);
  modport sink   (input valid, player_x, player_y, ray_angle, output ready);
endinterface

// ===== rtl/grwc_col_if.sv =====
// Column word channel: hit point, distance and wall column, valid/ready handshake.
// Depends on grwc_pkg.
interface grwc_col_if;
  import grwc_pkg::*;

  logic                valid;
  logic                ready;
  logic [POS_W-1:0]    hit_x;
  logic [POS_W-1:0]    hit_y;
  logic [DIST_W-1:0]   hit_distance;
  logic                vertical_side;
  logic                hit_found;
  logic [HEIGHT_W-1:0] line_height;
  logic [OFFSET_W-1:0] line_offset;

  modport source (output valid, hit_x, hit_y, hit_distance, vertical_side, hit_found,
                  line_height, line_offset, input ready);
  modport sink   (input valid, hit_x, hit_y, hit_distance, vertical_side, hit_found,
                  line_height, line_offset, output ready);
endinterface

// ===== rtl/grid_ray_wall_cast_unit.sv =====
// Grid ray wall caster: one ray word in, one wall column word out, fully pipelined.
// Depends on grwc_pkg, grwc_ray_if and grwc_col_if.
//
// Usage: load the 64-bit wall map (bit row*8+col set = wall) through wall_map_we_i /
// wall_map_i while no ray is in flight, then stream rays. The pipeline takes one ray
// word per cycle unless the column side stalls, and returns column words in order. The
// chain is 1 tangent stage, a 10-stage reciprocal divider (3 quotient bits per stage)
// for the cotangent, 3 setup stages, 8 grid-march stages (one gridline crossing per
// stage for both passes at once), 2 distance stages, an 18-stage square root (one
// result bit per stage), a 3-stage height divider and the output register.
// A stall on the column side freezes every stage together; nothing is dropped or
// repeated, and bubbles still drain while the output register is empty. Rays exactly
// on an axis skip the pass that never crosses a gridline; cells off the map are open.
// With no wall met the word carries the player position, distance 262143, height 0.
module grid_ray_wall_cast_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wall_map_we_i,
  input  logic [grwc_pkg::MAP_BITS-1:0] wall_map_i,
  grwc_ray_if.sink                      ray_i,
  grwc_col_if.source                    col_o
);
  import grwc_pkg::*;

  // internal widths
  localparam int QANG_W     = ANG_W - 2;          // angle within a quadrant
  localparam int QTR_ANG    = 2**QANG_W;
  localparam int OCT_ANG    = 2**(QANG_W - 1);
  localparam int FRAC_W     = 8;
  localparam int TDIFF_W    = 12;
  localparam int RATIO_W    = 30;                 // floor(2^32/6) fits
  localparam int REM_W      = TAN_W;
  localparam int DIV_BITS   = 3;
  localparam int DIV_STAGES = RATIO_W / DIV_BITS;
  localparam int RECIP_INIT = 4;                  // 2^32 >> RATIO_W
  localparam int GAP_W      = CELL_SHIFT + 1;
  localparam int PROD_W     = GAP_W + RATIO_W;
  localparam int OFF_W      = PROD_W + 1 - 16;
  localparam int ST_W       = RATIO_W - 1;
  localparam int RA_W       = POS_W + 3;
  localparam int RB_W       = 34;
  localparam int SQ_W       = 2 * POS_W;
  localparam int SQV_W      = SQ_W + 1;
  localparam int SQR_W      = SQV_W + 1;
  localparam int SQ_STAGES  = DIST_W;
  localparam int HQ_BITS    = HEIGHT_W;
  localparam int HD_BITS    = 3;
  localparam int HD_STAGES  = HQ_BITS / HD_BITS;
  localparam int HREM_W     = DIST_W;
  localparam int HNUM_W     = $clog2(HEIGHT_NUM) + 1;
  localparam int NST        = 1 + DIV_STAGES + 3 + MAX_STEPS + 2 + SQ_STAGES + HD_STAGES + 1;

  localparam logic [HNUM_W-1:0] HNUM = HNUM_W'(HEIGHT_NUM);

  typedef struct packed {
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [1:0]       q;
    logic             u_zero;
    logic             u_le;
    logic [TAN_W-1:0] t;
  } front_t;

  typedef struct packed {
    front_t             f;
    logic [REM_W-1:0]   rem;
    logic [RATIO_W-1:0] quo;
  } recip_t;

  typedef struct packed {
    logic [POS_W-1:0]   px;
    logic [POS_W-1:0]   py;
    logic [RATIO_W-1:0] ratio_h;
    logic [RATIO_W-1:0] ratio_v;
    logic               x_pos;
    logic               y_pos;
    logic               run_h;
    logic               run_v;
  } setup_t;

  typedef struct packed {
    logic [POS_W-1:0]       px;
    logic [POS_W-1:0]       py;
    logic [PROD_W-1:0]      prod_h;
    logic [PROD_W-1:0]      prod_v;
    logic [ST_W-1:0]        st_h;
    logic [ST_W-1:0]        st_v;
    logic signed [RA_W-1:0] ra_h;
    logic signed [RA_W-1:0] ra_v;
    logic                   x_pos;
    logic                   y_pos;
    logic                   run_h;
    logic                   run_v;
  } mult_t;

  typedef struct packed {
    logic                   run;
    logic                   found;
    logic                   neg_a;
    logic                   neg_b;
    logic [ST_W-1:0]        st;
    logic signed [RA_W-1:0] ra;
    logic signed [RB_W-1:0] rb;
  } pass_t;

  typedef struct packed {
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    pass_t            h;
    pass_t            v;
  } march_t;

  typedef struct packed {
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic             fh;
    logic             fv;
    logic [POS_W-1:0] hx;
    logic [POS_W-1:0] hy;
    logic [POS_W-1:0] vx;
    logic [POS_W-1:0] vy;
    logic [SQ_W-1:0]  sq_hx;
    logic [SQ_W-1:0]  sq_hy;
    logic [SQ_W-1:0]  sq_vx;
    logic [SQ_W-1:0]  sq_vy;
  } dist_t;

  typedef struct packed {
    logic [SQV_W-1:0] v;
    logic [SQR_W-1:0] r;
    logic [POS_W-1:0] rx;
    logic [POS_W-1:0] ry;
    logic             vert;
    logic             found;
  } root_t;

  typedef struct packed {
    logic [HREM_W-1:0]  rem;
    logic [HQ_BITS-1:0] quo;
    logic [DIST_W-1:0]  d;
    logic               sat;
    logic [POS_W-1:0]   rx;
    logic [POS_W-1:0]   ry;
    logic               vert;
    logic               found;
  } hdiv_t;

  typedef struct packed {
    logic [POS_W-1:0]    hit_x;
    logic [POS_W-1:0]    hit_y;
    logic [DIST_W-1:0]   hit_distance;
    logic                vertical_side;
    logic                hit_found;
    logic [HEIGHT_W-1:0] line_height;
    logic [OFFSET_W-1:0] line_offset;
  } col_t;

  // three quotient bits of floor(2^32 / t); dividend bits below 2^30 are zero
  function automatic recip_t recip_step(recip_t s);
    recip_t         o;
    logic [REM_W:0] tr;
    o = s;
    for (int i = 0; i < DIV_BITS; i++) begin
      tr = {o.rem, 1'b0};
      if (tr >= {1'b0, o.f.t}) begin
        o.rem = REM_W'(tr - {1'b0, o.f.t});
        o.quo = {o.quo[RATIO_W-2:0], 1'b1};
      end else begin
        o.rem = tr[REM_W-1:0];
        o.quo = {o.quo[RATIO_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  // wall test; points off the map are open
  function automatic logic wall_at(logic [MAP_BITS-1:0] m, logic signed [RB_W-1:0] x,
                                   logic signed [RB_W-1:0] y);
    logic on_map;
    on_map = (x[RB_W-1:POS_W] == '0) && (y[RB_W-1:POS_W] == '0);
    return on_map && m[{y[POS_W-1:CELL_SHIFT], x[POS_W-1:CELL_SHIFT]}];
  endfunction

  // one gridline crossing; a found pass freezes on its hit point
  function automatic pass_t pass_step(pass_t p, logic wall);
    pass_t o;
    o = p;
    if (p.run && !p.found) begin
      if (wall) begin
        o.found = 1'b1;
      end else begin
        o.ra = p.neg_a ? p.ra - RA_W'(CELL_Q) : p.ra + RA_W'(CELL_Q);
        o.rb = p.neg_b ? p.rb - $signed(RB_W'(p.st)) : p.rb + $signed(RB_W'(p.st));
      end
    end
    return o;
  endfunction

  // one result bit of the integer square root
  function automatic root_t root_step(root_t s, int sh);
    root_t            o;
    logic [SQR_W-1:0] bv;
    logic [SQR_W-1:0] trial;
    o     = s;
    bv    = SQR_W'(1) << sh;
    trial = o.r + bv;
    if ({1'b0, o.v} >= trial) begin
      o.v = SQV_W'({1'b0, o.v} - trial);
      o.r = (o.r >> 1) + bv;
    end else begin
      o.r = o.r >> 1;
    end
    return o;
  endfunction

  // three quotient bits of HEIGHT_NUM / d
  function automatic hdiv_t hdiv_step(hdiv_t s, int k);
    hdiv_t           o;
    logic [HREM_W:0] tr;
    int              pos;
    o = s;
    for (int i = 0; i < HD_BITS; i++) begin
      pos = HQ_BITS - 1 - (k * HD_BITS + i);
      tr  = {o.rem, HNUM[pos]};
      if (tr >= {1'b0, o.d}) begin
        o.rem = HREM_W'(tr - {1'b0, o.d});
        o.quo = {o.quo[HQ_BITS-2:0], 1'b1};
      end else begin
        o.rem = tr[HREM_W-1:0];
        o.quo = {o.quo[HQ_BITS-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // control: one enable for the whole pipe, valid bits shift with the data
  // ---------------------------------------------------------------------------
  logic [MAP_BITS-1:0] wall_map_q;
  logic [NST-1:0]      vld_q, vld_d;
  logic                en;
  logic                in_acc;

  assign en          = !vld_q[NST-1] || col_o.ready;
  assign in_acc      = ray_i.valid && en;
  assign ray_i.ready = en;
  assign vld_d       = {vld_q[NST-2:0], in_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      wall_map_q <= '0;
    end else begin
      if (en) vld_q <= vld_d;
      if (wall_map_we_i) wall_map_q <= wall_map_i;
    end
  end

  // ---------------------------------------------------------------------------
  // stage A: octant fold and interpolated tangent
  // ---------------------------------------------------------------------------
  logic [QANG_W-1:0]       a_u, a_r;
  logic                    a_le;
  logic [TIDX_W-1:0]       a_idx;
  logic [FRAC_W-1:0]       a_frac;
  logic [TAN_W-1:0]        a_lo, a_hi;
  logic [TDIFF_W-1:0]      a_diff;
  logic [TDIFF_W+FRAC_W:0] a_prod;
  front_t                  a_d, a_q;

  always_comb begin
    a_u    = ray_i.ray_angle[QANG_W-1:0];
    a_le   = a_u <= QANG_W'(OCT_ANG);
    a_r    = a_le ? a_u : QANG_W'((QANG_W+1)'(QTR_ANG) - {1'b0, a_u});
    a_idx  = a_r[QANG_W-1:FRAC_W];
    a_frac = a_r[FRAC_W-1:0];
    a_lo   = tan_tab(a_idx);
    a_hi   = tan_tab(a_idx + TIDX_W'(1));
    a_diff = TDIFF_W'(a_hi - a_lo);
    a_prod = (TDIFF_W+FRAC_W+1)'(a_diff * a_frac) + (TDIFF_W+FRAC_W+1)'(128);
    a_d.px     = ray_i.player_x;
    a_d.py     = ray_i.player_y;
    a_d.q      = ray_i.ray_angle[ANG_W-1:QANG_W];
    a_d.u_zero = (a_u == '0);
    a_d.u_le   = a_le;
    a_d.t      = a_lo + TAN_W'(a_prod[TDIFF_W+FRAC_W:FRAC_W]);
  end

  // ---------------------------------------------------------------------------
  // reciprocal divider: floor(2^32 / t)
  // ---------------------------------------------------------------------------
  recip_t rc_d [DIV_STAGES];
  recip_t rc_q [DIV_STAGES];

  always_comb begin
    rc_d[0] = recip_step('{f: a_q, rem: REM_W'(RECIP_INIT), quo: '0});
    for (int k = 1; k < DIV_STAGES; k++) rc_d[k] = recip_step(rc_q[k-1]);
  end

  // ---------------------------------------------------------------------------
  // stage B: pick tan / cot per quadrant, direction flags, axis skips
  // ---------------------------------------------------------------------------
  front_t             b_f;
  logic [RATIO_W-1:0] b_tq, b_cq;
  setup_t             b_d, b_q;

  always_comb begin
    b_f  = rc_q[DIV_STAGES-1].f;
    b_tq = b_f.u_zero ? '0 : (b_f.u_le ? RATIO_W'(b_f.t) : rc_q[DIV_STAGES-1].quo);
    b_cq = b_f.u_zero ? '0 : (b_f.u_le ? rc_q[DIV_STAGES-1].quo : RATIO_W'(b_f.t));
    b_d.px      = b_f.px;
    b_d.py      = b_f.py;
    b_d.ratio_v = b_f.q[0] ? b_cq : b_tq;
    b_d.ratio_h = b_f.q[0] ? b_tq : b_cq;
    b_d.x_pos   = !(b_f.q[1] ^ b_f.q[0]);
    b_d.y_pos   = !b_f.q[1];
    b_d.run_h   = !(!b_f.q[0] && b_f.u_zero);
    b_d.run_v   = !(b_f.q[0] && b_f.u_zero);
  end

  // ---------------------------------------------------------------------------
  // stage C: first gridline, gap times ratio, per-step offset
  // ---------------------------------------------------------------------------
  logic [GAP_W-1:0]       c_gap_h, c_gap_v;
  logic signed [RA_W-1:0] c_base_x, c_base_y;
  logic [RATIO_W:0]       c_sth, c_stv;
  mult_t                  c_d, c_q;

  always_comb begin
    c_base_x = $signed(RA_W'({b_q.px[POS_W-1:CELL_SHIFT], {CELL_SHIFT{1'b0}}}));
    c_base_y = $signed(RA_W'({b_q.py[POS_W-1:CELL_SHIFT], {CELL_SHIFT{1'b0}}}));
    c_gap_v  = b_q.x_pos ? GAP_W'(CELL_Q) - GAP_W'(b_q.px[CELL_SHIFT-1:0])
                         : GAP_W'(b_q.px[CELL_SHIFT-1:0]) + GAP_W'(1);
    c_gap_h  = b_q.y_pos ? GAP_W'(CELL_Q) - GAP_W'(b_q.py[CELL_SHIFT-1:0])
                         : GAP_W'(b_q.py[CELL_SHIFT-1:0]) + GAP_W'(1);
    c_sth    = {1'b0, b_q.ratio_h} + (RATIO_W+1)'(2);
    c_stv    = {1'b0, b_q.ratio_v} + (RATIO_W+1)'(2);
    c_d.px     = b_q.px;
    c_d.py     = b_q.py;
    c_d.prod_h = PROD_W'(c_gap_h) * PROD_W'(b_q.ratio_h);
    c_d.prod_v = PROD_W'(c_gap_v) * PROD_W'(b_q.ratio_v);
    c_d.st_h   = c_sth[RATIO_W:2];   // round(CELL_Q * ratio / 2^16)
    c_d.st_v   = c_stv[RATIO_W:2];
    c_d.ra_h   = b_q.y_pos ? c_base_y + RA_W'(CELL_Q) : c_base_y - RA_W'(1);
    c_d.ra_v   = b_q.x_pos ? c_base_x + RA_W'(CELL_Q) : c_base_x - RA_W'(1);
    c_d.x_pos  = b_q.x_pos;
    c_d.y_pos  = b_q.y_pos;
    c_d.run_h  = b_q.run_h;
    c_d.run_v  = b_q.run_v;
  end

  // ---------------------------------------------------------------------------
  // stage D: rounded offset, starting point on the other axis
  // ---------------------------------------------------------------------------
  logic [PROD_W:0]        d_sum_h, d_sum_v;
  logic [OFF_W-1:0]       d_off_h, d_off_v;
  logic signed [RB_W-1:0] d_px, d_py;
  march_t                 d_d, d_q;

  always_comb begin
    d_sum_h = {1'b0, c_q.prod_h} + (PROD_W+1)'(32768);
    d_sum_v = {1'b0, c_q.prod_v} + (PROD_W+1)'(32768);
    d_off_h = d_sum_h[PROD_W:16];
    d_off_v = d_sum_v[PROD_W:16];
    d_px    = $signed(RB_W'(c_q.px));
    d_py    = $signed(RB_W'(c_q.py));
    d_d.px      = c_q.px;
    d_d.py      = c_q.py;
    d_d.h.run   = c_q.run_h;
    d_d.h.found = 1'b0;
    d_d.h.neg_a = !c_q.y_pos;
    d_d.h.neg_b = !c_q.x_pos;
    d_d.h.st    = c_q.st_h;
    d_d.h.ra    = c_q.ra_h;
    d_d.h.rb    = c_q.x_pos ? d_px + $signed(RB_W'(d_off_h)) : d_px - $signed(RB_W'(d_off_h));
    d_d.v.run   = c_q.run_v;
    d_d.v.found = 1'b0;
    d_d.v.neg_a = !c_q.x_pos;
    d_d.v.neg_b = !c_q.y_pos;
    d_d.v.st    = c_q.st_v;
    d_d.v.ra    = c_q.ra_v;
    d_d.v.rb    = c_q.y_pos ? d_py + $signed(RB_W'(d_off_v)) : d_py - $signed(RB_W'(d_off_v));
  end

  // ---------------------------------------------------------------------------
  // march: one crossing per stage, horizontal and vertical passes side by side
  // ---------------------------------------------------------------------------
  march_t m_in [MAX_STEPS];
  march_t m_d  [MAX_STEPS];
  march_t m_q  [MAX_STEPS];

  always_comb begin
    m_in[0] = d_q;
    for (int k = 1; k < MAX_STEPS; k++) m_in[k] = m_q[k-1];
    for (int k = 0; k < MAX_STEPS; k++) begin
      m_d[k]    = m_in[k];
      // horizontal pass walks y gridlines: ra is y, rb is x
      m_d[k].h  = pass_step(m_in[k].h, wall_at(wall_map_q, m_in[k].h.rb,
                                               RB_W'(m_in[k].h.ra)));
      m_d[k].v  = pass_step(m_in[k].v, wall_at(wall_map_q, RB_W'(m_in[k].v.ra),
                                               m_in[k].v.rb));
    end
  end

  // ---------------------------------------------------------------------------
  // stage E: squared deltas of both hits
  // ---------------------------------------------------------------------------
  march_t                  e_m;
  logic signed [POS_W:0]   e_dhx, e_dhy, e_dvx, e_dvy;
  dist_t                   e_d, e_q;

  always_comb begin
    e_m    = m_q[MAX_STEPS-1];
    e_d.px = e_m.px;
    e_d.py = e_m.py;
    e_d.fh = e_m.h.found;
    e_d.fv = e_m.v.found;
    e_d.hx = e_m.h.rb[POS_W-1:0];
    e_d.hy = e_m.h.ra[POS_W-1:0];
    e_d.vx = e_m.v.ra[POS_W-1:0];
    e_d.vy = e_m.v.rb[POS_W-1:0];
    e_dhx  = $signed({1'b0, e_d.hx}) - $signed({1'b0, e_m.px});
    e_dhy  = $signed({1'b0, e_d.hy}) - $signed({1'b0, e_m.py});
    e_dvx  = $signed({1'b0, e_d.vx}) - $signed({1'b0, e_m.px});
    e_dvy  = $signed({1'b0, e_d.vy}) - $signed({1'b0, e_m.py});
    e_d.sq_hx = SQ_W'(e_dhx * e_dhx);
    e_d.sq_hy = SQ_W'(e_dhy * e_dhy);
    e_d.sq_vx = SQ_W'(e_dvx * e_dvx);
    e_d.sq_vy = SQ_W'(e_dvy * e_dvy);
  end

  // ---------------------------------------------------------------------------
  // stage F: nearer hit wins, a tie goes to the vertical side
  // ---------------------------------------------------------------------------
  logic [SQV_W-1:0] f_dh, f_dv;
  root_t            f_d, f_q;

  always_comb begin
    f_dh      = SQV_W'(e_q.sq_hx) + SQV_W'(e_q.sq_hy);
    f_dv      = SQV_W'(e_q.sq_vx) + SQV_W'(e_q.sq_vy);
    f_d.vert  = e_q.fv && (!e_q.fh || (f_dv <= f_dh));
    f_d.found = e_q.fh || e_q.fv;
    f_d.v     = f_d.vert ? f_dv : f_dh;
    f_d.r     = '0;
    f_d.rx    = !f_d.found ? e_q.px : (f_d.vert ? e_q.vx : e_q.hx);
    f_d.ry    = !f_d.found ? e_q.py : (f_d.vert ? e_q.vy : e_q.hy);
  end

  // ---------------------------------------------------------------------------
  // square root: one result bit per stage, high bit first
  // ---------------------------------------------------------------------------
  root_t rt_d [SQ_STAGES];
  root_t rt_q [SQ_STAGES];

  always_comb begin
    rt_d[0] = root_step(f_q, 2 * (SQ_STAGES - 1));
    for (int k = 1; k < SQ_STAGES; k++) rt_d[k] = root_step(rt_q[k-1], 2 * (SQ_STAGES - 1 - k));
  end

  // ---------------------------------------------------------------------------
  // height divider; near walls clamp, so only 9 quotient bits are needed
  // ---------------------------------------------------------------------------
  root_t rt_l;
  hdiv_t hd_init;
  hdiv_t hd_d [HD_STAGES];
  hdiv_t hd_q [HD_STAGES];

  always_comb begin
    rt_l          = rt_q[SQ_STAGES-1];
    hd_init.rem   = HREM_W'(HNUM >> HQ_BITS);
    hd_init.quo   = '0;
    hd_init.d     = rt_l.r[DIST_W-1:0];
    hd_init.sat   = rt_l.r[DIST_W-1:0] < DIST_W'(NEAR_DIST);
    hd_init.rx    = rt_l.rx;
    hd_init.ry    = rt_l.ry;
    hd_init.vert  = rt_l.vert;
    hd_init.found = rt_l.found;
    hd_d[0]       = hdiv_step(hd_init, 0);
    for (int k = 1; k < HD_STAGES; k++) hd_d[k] = hdiv_step(hd_q[k-1], k);
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  hdiv_t o_h;
  col_t  o_d, o_q;

  always_comb begin
    o_h = hd_q[HD_STAGES-1];
    o_d.hit_x         = o_h.rx;
    o_d.hit_y         = o_h.ry;
    o_d.vertical_side = o_h.vert;
    o_d.hit_found     = o_h.found;
    o_d.hit_distance  = o_h.found ? o_h.d : DIST_W'(DIST_SAT);
    o_d.line_height   = !o_h.found ? '0 : (o_h.sat ? HEIGHT_W'(SCREEN_HEIGHT) : o_h.quo);
    o_d.line_offset   = OFFSET_W'(SCREEN_HEIGHT / 2) - OFFSET_W'(o_d.line_height >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;
      for (int k = 0; k < DIV_STAGES; k++) rc_q[k] <= rc_d[k];
      b_q <= b_d;
      c_q <= c_d;
      d_q <= d_d;
      for (int k = 0; k < MAX_STEPS; k++) m_q[k] <= m_d[k];
      e_q <= e_d;
      f_q <= f_d;
      for (int k = 0; k < SQ_STAGES; k++) rt_q[k] <= rt_d[k];
      for (int k = 0; k < HD_STAGES; k++) hd_q[k] <= hd_d[k];
      o_q <= o_d;
    end
  end

  assign col_o.valid         = vld_q[NST-1];
  assign col_o.hit_x         = o_q.hit_x;
  assign col_o.hit_y         = o_q.hit_y;
  assign col_o.hit_distance  = o_q.hit_distance;
  assign col_o.vertical_side = o_q.vertical_side;
  assign col_o.hit_found     = o_q.hit_found;
  assign col_o.line_height   = o_q.line_height;
  assign col_o.line_offset   = o_q.line_offset;

endmodule

// ===== rtl/grwc_checker.sv =====
// Port-level checks on the column word channel of the grid ray wall caster.
// Depends on grwc_pkg; bound to grid_ray_wall_cast_unit below.
module grwc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          valid_i,
  input logic                          ready_i,
  input logic [grwc_pkg::POS_W-1:0]    hit_x_i,
  input logic [grwc_pkg::POS_W-1:0]    hit_y_i,
  input logic [grwc_pkg::DIST_W-1:0]   hit_distance_i,
  input logic                          vertical_side_i,
  input logic                          hit_found_i,
  input logic [grwc_pkg::HEIGHT_W-1:0] line_height_i,
  input logic [grwc_pkg::OFFSET_W-1:0] line_offset_i
);
  import grwc_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i)
    else $error("column word dropped while stalled");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> $stable({hit_x_i, hit_y_i, hit_distance_i, vertical_side_i,
                                     hit_found_i, line_height_i, line_offset_i}))
    else $error("column word changed while stalled");

  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !hit_found_i |-> hit_distance_i == DIST_W'(DIST_SAT) &&
                                line_height_i == '0 && !vertical_side_i)
    else $error("miss word carries hit data");

  a_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> line_height_i <= HEIGHT_W'(SCREEN_HEIGHT) &&
                line_offset_i == OFFSET_W'(SCREEN_HEIGHT / 2) - OFFSET_W'(line_height_i >> 1))
    else $error("column height and offset disagree");

  a_near: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && hit_found_i && hit_distance_i < DIST_W'(NEAR_DIST) |->
      line_height_i == HEIGHT_W'(SCREEN_HEIGHT))
    else $error("near wall not clamped to full height");

endmodule

bind grid_ray_wall_cast_unit grwc_checker u_grwc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .valid_i         (col_o.valid),
  .ready_i         (col_o.ready),
  .hit_x_i         (col_o.hit_x),
  .hit_y_i         (col_o.hit_y),
  .hit_distance_i  (col_o.hit_distance),
  .vertical_side_i (col_o.vertical_side),
  .hit_found_i     (col_o.hit_found),
  .line_height_i   (col_o.line_height),
  .line_offset_i   (col_o.line_offset)
);

// ===== tb/grid_ray_wall_cast_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for grid_ray_wall_cast_unit: directed and random ray words,
// each column word compared field by field against a fixed-point predictor.
// Depends on grwc_pkg, grwc_ray_if, grwc_col_if and the block itself.
module grid_ray_wall_cast_unit_tb;
  import grwc_pkg::*;

  localparam int LATENCY  = 46;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [POS_W-1:0]    hit_x;
    logic [POS_W-1:0]    hit_y;
    logic [DIST_W-1:0]   hit_distance;
    logic                vertical_side;
    logic                hit_found;
    logic [HEIGHT_W-1:0] line_height;
    logic [OFFSET_W-1:0] line_offset;
  } column_t;

  // one directed row: ray, map to load first, and an optional typed-in column
  typedef struct {
    logic [POS_W-1:0]    px;
    logic [POS_W-1:0]    py;
    logic [ANG_W-1:0]    ang;
    logic [MAP_BITS-1:0] map;
    bit                  load_map;
    bit                  has_known;
    column_t             known;
  } ray_row_t;

  logic clk_i;
  logic rst_ni;
  logic wall_map_we_i;
  logic [MAP_BITS-1:0] wall_map_i;

  grwc_ray_if ray_ch ();
  grwc_col_if col_ch ();

  grid_ray_wall_cast_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wall_map_we_i (wall_map_we_i),
    .wall_map_i    (wall_map_i),
    .ray_i         (ray_ch.sink),
    .col_o         (col_ch.source)
  );

  // model copy of the wall map, updated in step with each register write
  logic [MAP_BITS-1:0] map_shadow;
  column_t             pending_cols[$];
  int                  error_count;
  int                  idle_cycles;
  bit                  sink_busy_free;   // no stalls on the column side
  bit                  source_busy_free; // no gaps on the ray side
  bit                  timed_out;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------- predictor ----------------

  function automatic longint unsigned oct_tangent(input int unsigned r);
    int unsigned idx, frac;
    longint unsigned lo, hi;
    idx  = r >> 8;
    frac = r & 255;
    if (idx >= 32) return 65536;
    lo = longint'(tan_tab(6'(idx)));
    hi = longint'(tan_tab(6'(idx + 1)));
    return lo + (((hi - lo) * frac + 128) >> 8);
  endfunction

  function automatic longint unsigned quad_tangent(input int unsigned u, input bit cot);
    bit near_lo;
    if (u == 0) return 0;
    near_lo = (u <= 8192);
    if (near_lo != cot) return oct_tangent(near_lo ? u : 16384 - u);
    return (64'd1 << 32) / oct_tangent(near_lo ? u : 16384 - u);
  endfunction

  function automatic bit is_wall(input longint x, input longint y);
    longint mx, my;
    if (x < 0 || y < 0) return 1'b0;
    mx = x / CELL_Q;
    my = y / CELL_Q;
    if (mx >= MAP_SIZE || my >= MAP_SIZE) return 1'b0;
    return map_shadow[my * MAP_SIZE + mx];
  endfunction

  // walk the gridlines across axis a; ratio is |db/da| in Q16
  function automatic bit walk_gridlines(input longint pa, input longint pb, input bit a_pos,
                                        input bit b_pos, input longint unsigned ratio,
                                        input bit a_is_y, output longint ha,
                                        output longint hb);
    longint base, ra, rb, sa, sb;
    longint unsigned gap, off, st;
    base = (pa / CELL_Q) * CELL_Q;
    ha = 0;
    hb = 0;
    if (a_pos) begin
      ra = base + CELL_Q; gap = ra - pa; sa = CELL_Q;
    end else begin
      ra = base - 1; gap = pa - ra; sa = -CELL_Q;
    end
    off = (gap * ratio + 32768) >> 16;
    st  = (longint'(CELL_Q) * ratio + 32768) >> 16;
    rb  = b_pos ? pb + longint'(off) : pb - longint'(off);
    sb  = b_pos ? longint'(st) : -longint'(st);
    for (int i = 0; i < MAX_STEPS; i++) begin
      if (a_is_y ? is_wall(rb, ra) : is_wall(ra, rb)) begin
        ha = ra;
        hb = rb;
        return 1'b1;
      end
      ra += sa;
      rb += sb;
    end
    return 1'b0;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic column_t cast_column(input logic [POS_W-1:0] pxi,
                                          input logic [POS_W-1:0] pyi,
                                          input logic [ANG_W-1:0] ang);
    column_t c;
    longint px, py, hx, hy, vx, vy, rx, ry, dx, dy;
    int unsigned q, u;
    longint unsigned tq, cq, tmag, cmag, dh, dv, d2, ray_len, height;
    bit xp, yp, hh, hv, vert;
    px = pxi; py = pyi;
    q  = ang >> 14;
    u  = ang & 16'h3FFF;
    tq = quad_tangent(u, 1'b0);
    cq = quad_tangent(u, 1'b1);
    tmag = q[0] ? cq : tq;
    cmag = q[0] ? tq : cq;
    xp = (q == 0 || q == 3);
    yp = (q < 2);
    hh = 0; hv = 0; vert = 0;
    hx = px; hy = py; vx = px; vy = py; rx = px; ry = py;
    ray_len = DIST_SAT;
    height = 0;
    // axis rays skip the pass that never crosses a gridline
    if (!(q[0] == 0 && u == 0)) hh = walk_gridlines(py, px, yp, xp, cmag, 1'b1, hy, hx);
    if (!(q[0] == 1 && u == 0)) hv = walk_gridlines(px, py, xp, yp, tmag, 1'b0, vx, vy);
    if (hh || hv) begin
      dx = hx - px; dy = hy - py; dh = dx * dx + dy * dy;
      dx = vx - px; dy = vy - py; dv = dx * dx + dy * dy;
      if (hv && (!hh || dv <= dh)) begin
        vert = 1; rx = vx; ry = vy; d2 = dv;
      end else begin
        rx = hx; ry = hy; d2 = dh;
      end
      ray_len = int_sqrt(d2);
      if (ray_len > DIST_SAT) ray_len = DIST_SAT;
      height = (ray_len == 0) ? SCREEN_HEIGHT : longint'(HEIGHT_NUM) / ray_len;
      if (height > SCREEN_HEIGHT) height = SCREEN_HEIGHT;
    end
    c.hit_x         = rx[POS_W-1:0];
    c.hit_y         = ry[POS_W-1:0];
    c.hit_distance  = ray_len[DIST_W-1:0];
    c.vertical_side = vert;
    c.hit_found     = hh || hv;
    c.line_height   = height[HEIGHT_W-1:0];
    c.line_offset   = OFFSET_W'(SCREEN_HEIGHT / 2 - (height >> 1));
    return c;
  endfunction

  // ---------------- checking ----------------

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: column %s got %0d, want %0d", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && col_ch.valid && col_ch.ready) begin
      column_t got, want;
      got = '{col_ch.hit_x, col_ch.hit_y, col_ch.hit_distance, col_ch.vertical_side,
              col_ch.hit_found, col_ch.line_height, col_ch.line_offset};
      if (pending_cols.size() == 0) begin
        report_mismatch("word with nothing expected, hit_x", got.hit_x, -1);
      end else begin
        want = pending_cols.pop_front();
        if (got.hit_x != want.hit_x) report_mismatch("hit_x", got.hit_x, want.hit_x);
        if (got.hit_y != want.hit_y) report_mismatch("hit_y", got.hit_y, want.hit_y);
        if (got.hit_distance != want.hit_distance)
          report_mismatch("hit_distance", got.hit_distance, want.hit_distance);
        if (got.vertical_side != want.vertical_side)
          report_mismatch("vertical_side", got.vertical_side, want.vertical_side);
        if (got.hit_found != want.hit_found)
          report_mismatch("hit_found", got.hit_found, want.hit_found);
        if (got.line_height != want.line_height)
          report_mismatch("line_height", got.line_height, want.line_height);
        if (got.line_offset != want.line_offset)
          report_mismatch("line_offset", got.line_offset, want.line_offset);
      end
    end
  end

  // column side: stall at random, about 26 percent of the time, unless a no-stall stretch is on
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_ch.ready <= 1'b0;
    end else begin
      col_ch.ready <= sink_busy_free || ($urandom_range(99) >= 26);
    end
  end

  // watchdog: cycles in a row with no word accepted on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (ray_ch.valid && ray_ch.ready) || (col_ch.valid && col_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) timed_out <= 1'b1;
  end

  initial begin
    wait (timed_out);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------- stimulus ----------------

  // send one ray word; holds valid across back-to-back words, drops it on a gap
  task automatic send_ray(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                          input logic [ANG_W-1:0] ang);
    while (!source_busy_free && $urandom_range(99) < 26) begin
      ray_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    ray_ch.valid     <= 1'b1;
    ray_ch.player_x  <= px;
    ray_ch.player_y  <= py;
    ray_ch.ray_angle <= ang;
    pending_cols.push_back(cast_column(px, py, ang));
    do @(posedge clk_i); while (!ray_ch.ready);
  endtask

  task automatic drain_columns();
    ray_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cols.size() != 0) @(posedge clk_i);
    repeat (LATENCY / 4) @(posedge clk_i);
  endtask

  task automatic load_map(input logic [MAP_BITS-1:0] m);
    drain_columns();
    wall_map_we_i <= 1'b1;
    wall_map_i    <= m;
    map_shadow    = m;
    @(posedge clk_i);
    wall_map_we_i <= 1'b0;
  endtask

  // a ray from a random spot, biased toward the inside of the map
  task automatic send_random_ray();
    logic [POS_W-1:0] px, py;
    logic [ANG_W-1:0] ang;
    case ($urandom_range(9))
      0:       px = POS_W'($urandom);
      1:       px = {2'b00, 6'($urandom_range(63)), 9'($urandom)} |
                    POS_W'(17'h8000 * $urandom_range(3));
      default: px = 17'($urandom_range(MAP_SIZE * CELL_Q - 1));
    endcase
    py = ($urandom_range(9) == 0) ? POS_W'($urandom)
                                  : 17'($urandom_range(MAP_SIZE * CELL_Q - 1));
    case ($urandom_range(11))
      0:       ang = 16'(16384 * $urandom_range(3));
      1:       ang = 16'(16384 * $urandom_range(3) + 8192);
      2:       ang = 16'(16384 * $urandom_range(3) + $urandom_range(2) - 1);
      default: ang = ANG_W'($urandom);
    endcase
    send_ray(px, py, ang);
  endtask

  // bordered room: walls all round the 8x8 edge
  localparam logic [MAP_BITS-1:0] ROOM_MAP = 64'hFF81_8181_8181_81FF;
  localparam column_t NO_HIT_AT_ORIGIN = '{0, 0, DIST_SAT, 1'b0, 1'b0, 0, 160};
  localparam column_t NO_HIT_AT_MAX    = '{17'h1FFFF, 17'h1FFFF, DIST_SAT, 1'b0, 1'b0, 0, 160};

  ray_row_t directed_rows[$];

  initial begin
    ray_row_t row;
    column_t  want;
    logic [MAP_BITS-1:0] m;
    error_count      = 0;
    map_shadow       = '0;
    sink_busy_free   = 1'b0;
    source_busy_free = 1'b0;
    rst_ni           = 1'b0;
    wall_map_we_i    = 1'b0;
    wall_map_i       = '0;
    ray_ch.valid     = 1'b0;
    ray_ch.player_x  = '0;
    ray_ch.player_y  = '0;
    ray_ch.ray_angle = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: until the first map load the map is empty after reset, so nothing is hit
    directed_rows = '{
      '{0, 0, 0, 0, 0, 1, NO_HIT_AT_ORIGIN},
      '{17'h1FFFF, 17'h1FFFF, 16'hFFFF, 0, 0, 1, NO_HIT_AT_MAX},
      '{17'h8000, 17'h8000, 16'h2000, 0, 0, 0, '0},
      '{17'h8020, 17'h8040, 0, ROOM_MAP, 1, 0, '0},
      '{17'h8020, 17'h8040, 16384, 0, 0, 0, '0},
      '{17'h8020, 17'h8040, 32768, 0, 0, 0, '0},
      '{17'h8020, 17'h8040, 49152, 0, 0, 0, '0},
      '{17'h8000, 17'h8000, 8192, 0, 0, 0, '0},      // diagonal: equal distances
      '{17'h8000, 17'h8000, 24576, 0, 0, 0, '0},
      '{17'h8000, 17'h8000, 40960, 0, 0, 0, '0},
      '{17'h8000, 17'h8000, 57344, 0, 0, 0, '0},
      '{17'h4000, 17'h4000, 1, 0, 0, 0, '0},
      '{17'h4000, 17'h4000, 16383, 0, 0, 0, '0},
      '{17'h4000, 17'h4000, 65535, 0, 0, 0, '0},
      '{17'h1FFFF, 17'h1FFFF, 40000, 0, 0, 0, '0},   // start in the far corner cell of the map
      '{17'h0100, 17'h0100, 40960, 64'h1, 1, 0, '0}, // cell zero is a wall
      '{17'h0100, 17'h0100, 8192, 0, 0, 0, '0},
      '{17'h0000, 17'h0000, 8192, 0, 0, 0, '0},      // inside a wall cell, which the march never tests
      '{17'h3FFF, 17'h3FFF, 12345, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, '0},
      '{17'h3FFF, 17'h4000, 33000, 0, 0, 0, '0},
      '{17'h4000, 17'h3FFF, 50000, 0, 0, 0, '0},
      '{17'h00FF, 17'h1FF00, 7000, 64'h8000_0000_0000_0000, 1, 0, '0}
    };
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.load_map) load_map(row.map);
      if (row.has_known) begin
        want = cast_column(row.px, row.py, row.ang);
        if (want != row.known) report_mismatch("typed-in row, hit_x", row.known.hit_x, i);
      end
      send_ray(row.px, row.py, row.ang);
    end

    // random part: several maps, each a phase of rays
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: m = ROOM_MAP;
        1: m = {$urandom, $urandom} & {$urandom, $urandom};
        2: m = {$urandom, $urandom};
        default: m = (phase == 11) ? '1 : 64'h0;
      endcase
      load_map(m);
      // phase 5: no gaps and no stalls at all, back to back
      source_busy_free = (phase == 5);
      sink_busy_free   = (phase == 5);
      for (int n = 0; n < 75; n++) begin
        send_random_ray();
        // once, in phase 2, hold off until every column has come back
        if (phase == 2 && n == 30) drain_columns();
      end
    end
    source_busy_free = 1'b0;
    sink_busy_free   = 1'b0;

    drain_columns();
    repeat (LATENCY) @(posedge clk_i);
    if (error_count == 0 && pending_cols.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
